@@ hw/rtl/ardse_pkg.sv @@
`default_nettype none

package ardse_pkg;

	localparam int MAX_DIM = 4;
	localparam int IDX_W   = 2;
	localparam int MUL_A_W = 32;
	localparam int MUL_B_W = 17;
	localparam int MUL_P_W = MUL_A_W + MUL_B_W;

	localparam logic [23:0] SUM_MAX   = 24'hFF_FFFF;
	localparam logic [16:0] LOG2E_Q16 = 17'd94548;
	localparam logic [16:0] LN2_Q16   = 17'd45426;
	localparam logic [16:0] ONE_Q16   = 17'd65536;

	// register indexes on the configuration port
	localparam logic [2:0] REG_DIMS    = 3'd0;
	localparam logic [2:0] REG_INV_0   = 3'd1;
	localparam logic [2:0] REG_INV_1   = 3'd2;
	localparam logic [2:0] REG_INV_2   = 3'd3;
	localparam logic [2:0] REG_INV_3   = 3'd4;
	localparam logic [2:0] REG_SIG_VAR = 3'd5;
	localparam logic [2:0] REG_NOISE   = 3'd6;

	typedef struct packed {
		logic [15:0] coord_first;
		logic [15:0] coord_second;
		logic        on_diagonal;
	} ardse_in_t;

	typedef struct packed {
		logic [24:0] kernel_value;
		logic        saturated;
	} ardse_out_t;

	typedef struct packed {
		logic [2:0]                 dims_in_use;
		logic [MAX_DIM-1:0][15:0]   inv_len_sq;
		logic [15:0]                signal_variance;
		logic [15:0]                noise_variance;
	} ardse_cfg_t;

	// operand pairs for the shared multiplier
	typedef enum logic [2:0] {
		MUL_DIFF_SQ = 3'd0,
		MUL_SCALE   = 3'd1,
		MUL_LOG2E   = 3'd2,
		MUL_LN2     = 3'd3,
		MUL_HORNER  = 3'd4,
		MUL_RECIP   = 3'd5,
		MUL_AMP     = 3'd6
	} ardse_mul_sel_t;

	typedef struct packed {
		logic           in_take;
		logic           mul_en;
		ardse_mul_sel_t mul_sel;
		logic           acc_en;
		logic           frac_en;
		logic           horner_init;
		logic           horner_sub;
		logic           out_load;
	} ardse_cmd_t;

	typedef struct packed {
		logic is_last;
		logic horner_done;
	} ardse_status_t;

	typedef struct packed {
		logic [15:0] mult;
		logic [4:0]  shift;
	} ardse_recip_t;

	// floor(p/k) = (p*mult) >> shift, exact for any 16-bit p
	function automatic ardse_recip_t horner_recip(input logic [2:0] k);
		ardse_recip_t r;
		begin
			unique case (k)
				3'd5:    r = '{mult: 16'd52429, shift: 5'd18};
				3'd4:    r = '{mult: 16'd1,     shift: 5'd2};
				3'd3:    r = '{mult: 16'd43691, shift: 5'd17};
				3'd2:    r = '{mult: 16'd1,     shift: 5'd1};
				default: r = '{mult: 16'd1,     shift: 5'd0};
			endcase
			return r;
		end
	endfunction

endpackage

`default_nettype wire

@@ hw/rtl/ardse_cfg.sv @@
`default_nettype none

module ardse_cfg (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire logic [2:0]        cfg_index,
	input  wire logic [15:0]       cfg_data,
	output ardse_pkg::ardse_cfg_t  cfg
);

	ardse_pkg::ardse_cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.dims_in_use     <= 3'd4;
			cfg_q.inv_len_sq      <= {ardse_pkg::MAX_DIM{16'd256}};
			cfg_q.signal_variance <= 16'd256;
			cfg_q.noise_variance  <= 16'd0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				ardse_pkg::REG_DIMS:    cfg_q.dims_in_use     <= cfg_data[2:0];
				ardse_pkg::REG_INV_0:   cfg_q.inv_len_sq[0]   <= cfg_data;
				ardse_pkg::REG_INV_1:   cfg_q.inv_len_sq[1]   <= cfg_data;
				ardse_pkg::REG_INV_2:   cfg_q.inv_len_sq[2]   <= cfg_data;
				ardse_pkg::REG_INV_3:   cfg_q.inv_len_sq[3]   <= cfg_data;
				ardse_pkg::REG_SIG_VAR: cfg_q.signal_variance <= cfg_data;
				ardse_pkg::REG_NOISE:   cfg_q.noise_variance  <= cfg_data;
				default: ; // unmapped index, write dropped
			endcase
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/ardse_dp.sv @@
`default_nettype none

module ardse_dp (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire ardse_pkg::ardse_cfg_t cfg,
	input  wire ardse_pkg::ardse_in_t  in_data,
	input  wire ardse_pkg::ardse_cmd_t cmd,
	output ardse_pkg::ardse_status_t   status,
	output ardse_pkg::ardse_out_t      out_data
);

	logic [15:0]                     diff_q;
	logic                            diag_q;
	logic [ardse_pkg::MUL_P_W-1:0]   mul_q;
	logic [23:0]                     sum_q;
	logic [ardse_pkg::IDX_W-1:0]     idx_q;
	logic                            ovf_q;
	logic [7:0]                      n_q;
	logic [15:0]                     g_q;
	logic [16:0]                     r_q;
	logic [2:0]                      k_q;
	ardse_pkg::ardse_out_t           out_q;

	logic [15:0]                     diff;
	logic [ardse_pkg::MUL_A_W-1:0]   op_a;
	logic [ardse_pkg::MUL_B_W-1:0]   op_b;
	logic [ardse_pkg::MUL_P_W-1:0]   prod;
	logic [24:0]                     sum_wide;
	logic [2:0]                      dims_eff;
	logic [2:0]                      idx_next;
	ardse_pkg::ardse_recip_t         recip;
	logic [15:0]                     quot;
	logic [8:0]                      out_shift;
	logic [32:0]                     scaled;
	logic [24:0]                     kernel;

	assign diff = (in_data.coord_first >= in_data.coord_second)
		? in_data.coord_first - in_data.coord_second
		: in_data.coord_second - in_data.coord_first;

	assign recip = ardse_pkg::horner_recip(k_q);

	always_comb begin
		unique case (cmd.mul_sel)
			ardse_pkg::MUL_DIFF_SQ: begin
				op_a = {16'd0, diff_q};
				op_b = {1'b0, diff_q};
			end
			ardse_pkg::MUL_SCALE: begin
				op_a = mul_q[31:0];
				op_b = {1'b0, cfg.inv_len_sq[idx_q]};
			end
			ardse_pkg::MUL_LOG2E: begin
				op_a = {8'd0, sum_q};
				op_b = ardse_pkg::LOG2E_Q16;
			end
			ardse_pkg::MUL_LN2: begin
				op_a = {16'd0, mul_q[32:17]};
				op_b = ardse_pkg::LN2_Q16;
			end
			ardse_pkg::MUL_HORNER: begin
				op_a = {16'd0, g_q};
				op_b = r_q;
			end
			ardse_pkg::MUL_RECIP: begin
				op_a = {16'd0, mul_q[31:16]};
				op_b = {1'b0, recip.mult};
			end
			ardse_pkg::MUL_AMP: begin
				op_a = {16'd0, cfg.signal_variance};
				op_b = r_q;
			end
			default: begin
				op_a = '0;
				op_b = '0;
			end
		endcase
	end

	assign prod = {{ardse_pkg::MUL_B_W{1'b0}}, op_a} * {{ardse_pkg::MUL_A_W{1'b0}}, op_b};

	// term is (d*d*inv) >> 24, always within 24 bits
	assign sum_wide = {1'b0, sum_q} + {1'b0, mul_q[47:24]};

	always_comb begin
		if (cfg.dims_in_use == 3'd0)
			dims_eff = 3'd1;
		else if (cfg.dims_in_use > 3'(ardse_pkg::MAX_DIM))
			dims_eff = 3'(ardse_pkg::MAX_DIM);
		else
			dims_eff = cfg.dims_in_use;
	end

	assign idx_next = {1'b0, idx_q} + 3'd1;

	assign status.is_last     = idx_next >= dims_eff;
	assign status.horner_done = k_q == 3'd1;

	assign quot = 16'(mul_q[31:0] >> recip.shift);

	// result = (sv * r) >> (8 + n), zero once the shift clears the product
	assign out_shift = 9'd8 + {1'b0, n_q};
	assign scaled    = (out_shift >= 9'd40) ? 33'd0 : mul_q[32:0] >> out_shift[5:0];
	assign kernel    = scaled[24:0] + (diag_q ? {1'b0, cfg.noise_variance, 8'd0} : 25'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			idx_q <= '0;
			ovf_q <= 1'b0;
		end else if (cmd.out_load) begin
			sum_q <= '0;
			idx_q <= '0;
			ovf_q <= 1'b0;
		end else if (cmd.acc_en) begin
			if (sum_wide[24]) begin
				sum_q <= ardse_pkg::SUM_MAX;
				ovf_q <= 1'b1;
			end else begin
				sum_q <= sum_wide[23:0];
			end
			if (!status.is_last)
				idx_q <= idx_next[ardse_pkg::IDX_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.in_take) begin
			diff_q <= diff;
			diag_q <= in_data.on_diagonal;
		end
		if (cmd.mul_en)
			mul_q <= prod;
		if (cmd.frac_en)
			n_q <= mul_q[40:33];
		if (cmd.horner_init) begin
			g_q <= mul_q[31:16];
			r_q <= ardse_pkg::ONE_Q16;
			k_q <= 3'd5;
		end else if (cmd.horner_sub) begin
			r_q <= ardse_pkg::ONE_Q16 - {1'b0, quot};
			k_q <= k_q - 3'd1;
		end
		if (cmd.out_load) begin
			out_q.kernel_value <= kernel;
			out_q.saturated    <= ovf_q;
		end
	end

	assign out_data = out_q;

endmodule

`default_nettype wire

@@ hw/rtl/ardse_ctrl.sv @@
`default_nettype none

module ardse_ctrl (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     in_valid,
	output logic                          in_ready,
	output logic                          out_valid,
	input  wire logic                     out_ready,
	input  wire ardse_pkg::ardse_status_t status,
	output ardse_pkg::ardse_cmd_t         cmd
);

	typedef enum logic [11:0] {
		ST_IDLE   = 12'b0000_0000_0001,
		ST_SQ     = 12'b0000_0000_0010,
		ST_SCALE  = 12'b0000_0000_0100,
		ST_ACC    = 12'b0000_0000_1000,
		ST_LOG    = 12'b0000_0001_0000,
		ST_FRAC   = 12'b0000_0010_0000,
		ST_GINIT  = 12'b0000_0100_0000,
		ST_HMUL   = 12'b0000_1000_0000,
		ST_HDIV   = 12'b0001_0000_0000,
		ST_HSUB   = 12'b0010_0000_0000,
		ST_AMP    = 12'b0100_0000_0000,
		ST_OUT    = 12'b1000_0000_0000
	} ardse_state_t;

	ardse_state_t state_q, state_d;
	logic         out_valid_q;
	logic         out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = state_q == ST_IDLE;
	assign out_valid = out_valid_q;

	always_comb begin
		state_d         = state_q;
		cmd             = '0;
		cmd.mul_sel     = ardse_pkg::MUL_DIFF_SQ;
		unique case (state_q)
			ST_IDLE: begin
				cmd.in_take = in_valid;
				if (in_valid)
					state_d = ST_SQ;
			end
			ST_SQ: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = ardse_pkg::MUL_DIFF_SQ;
				state_d     = ST_SCALE;
			end
			ST_SCALE: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = ardse_pkg::MUL_SCALE;
				state_d     = ST_ACC;
			end
			ST_ACC: begin
				cmd.acc_en = 1'b1;
				state_d    = status.is_last ? ST_LOG : ST_IDLE;
			end
			ST_LOG: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = ardse_pkg::MUL_LOG2E;
				state_d     = ST_FRAC;
			end
			ST_FRAC: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = ardse_pkg::MUL_LN2;
				cmd.frac_en = 1'b1;
				state_d     = ST_GINIT;
			end
			ST_GINIT: begin
				cmd.horner_init = 1'b1;
				state_d         = ST_HMUL;
			end
			ST_HMUL: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = ardse_pkg::MUL_HORNER;
				state_d     = ST_HDIV;
			end
			ST_HDIV: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = ardse_pkg::MUL_RECIP;
				state_d     = ST_HSUB;
			end
			ST_HSUB: begin
				cmd.horner_sub = 1'b1;
				state_d        = status.horner_done ? ST_AMP : ST_HMUL;
			end
			ST_AMP: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = ardse_pkg::MUL_AMP;
				state_d     = ST_OUT;
			end
			ST_OUT: begin
				// hold until the result register is free
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/ard_squared_exponential_kernel_unit.sv @@
// ARD squared-exponential kernel: feed one coordinate pair per item, dimension 0 first, for
// dims_in_use items; the last one gives signal_variance*exp(-0.5*sum) in Q9.16, plus
// noise_variance when on_diagonal is set on it. Every product goes through one shared
// 32x17 multiplier, so the steps of an item run one after another and no new item is taken
// until the last is done: difference, square, scale, accumulate for each item; the last item
// then adds the base-2 split, the five-step Horner exp chain, the amplitude and final shift
// before the result is registered, waiting if the previous result has not been taken.
// Configuration writes take effect at once and must be made only while the block is idle.
`default_nettype none

module ard_squared_exponential_kernel_unit (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire ardse_pkg::ardse_in_t in_data,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output ardse_pkg::ardse_out_t     out_data,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [2:0]           cfg_index,
	input  wire logic [15:0]          cfg_data
);

	ardse_pkg::ardse_cfg_t    cfg;
	ardse_pkg::ardse_cmd_t    cmd;
	ardse_pkg::ardse_status_t status;

	ardse_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	ardse_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	ardse_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.in_data  (in_data),
		.cmd      (cmd),
		.status   (status),
		.out_data (out_data)
	);

endmodule

`default_nettype wire

@@ sim/ard_squared_exponential_kernel_unit_checker.sv @@
`default_nettype none

module ard_squared_exponential_kernel_unit_checker (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	input  wire logic                  in_ready,
	input  wire ardse_pkg::ardse_in_t  in_data,
	input  wire logic                  out_valid,
	input  wire logic                  out_ready,
	input  wire ardse_pkg::ardse_out_t out_data,
	input  wire logic                  cfg_valid,
	input  wire logic                  cfg_ready,
	input  wire logic [2:0]            cfg_index,
	input  wire logic [15:0]           cfg_data,
	output int                         mismatch_count,
	output int                         kernels_waiting,
	output int                         kernels_checked
);
	import ardse_pkg::*;

	localparam logic [23:0] DIST_CEIL    = 24'hFF_FFFF;
	localparam int          PRINT_BUDGET = 40;

	// register copy
	logic [2:0]  dims_reg;
	logic [15:0] inv_reg [MAX_DIM];
	logic [15:0] amp_reg;
	logic [15:0] noise_reg;

	// point-pair state
	logic [23:0] dist_acc;
	logic [1:0]  coord_pos;
	logic        sat_seen;

	ardse_out_t  kernel_due [$];
	ardse_out_t  due_head;
	int          mismatches;
	int          checked;

	assign mismatch_count  = mismatches;
	assign kernels_checked = checked;

	task automatic flag_mismatch(input string msg);
		mismatches++;
		if (mismatches <= PRINT_BUDGET)
			$display("MISMATCH @%0t: %s", $time, msg);
	endtask

	// amp * exp(-0.5*sum): base-2 split, then a 5-term Horner chain on the fraction
	function automatic logic [24:0] kernel_of_sum(input logic [23:0] s, input logic [15:0] amp);
		logic [63:0] u, whole, g, r, p;
		logic [15:0] frac;
		u = (64'(s) * 64'd94548) >> 17;
		whole = u >> 16;
		frac = u[15:0];
		g = (64'(frac) * 64'd45426) >> 16;
		r = 64'd65536;
		for (int k = 5; k >= 1; k--) begin
			p = (g * r) >> 16;
			r = 64'd65536 - p / 64'(k);
		end
		if (whole >= 64'd32)
			return '0;
		return 25'((64'(amp) * r) >> (whole + 64'd8));
	endfunction

	task automatic take_coord(input ardse_in_t it);
		logic [15:0] d;
		logic [63:0] term;
		logic [24:0] total;
		logic [2:0]  dims;
		ardse_out_t  res;
		dims = dims_reg;
		if (dims == 3'd0)
			dims = 3'd1;
		else if (dims > 3'(MAX_DIM))
			dims = 3'(MAX_DIM);
		d = (it.coord_first >= it.coord_second) ? it.coord_first - it.coord_second
		                                        : it.coord_second - it.coord_first;
		term = (64'(d) * 64'(d) * 64'(inv_reg[coord_pos])) >> 24;
		total = 25'(dist_acc) + 25'(term);
		if (total > 25'(DIST_CEIL)) begin
			total = 25'(DIST_CEIL);
			sat_seen = 1'b1;
		end
		dist_acc = total[23:0];
		// a count lowered mid-point closes the point on this item
		if ({1'b0, coord_pos} + 3'd1 < dims) begin
			coord_pos = coord_pos + 2'd1;
		end else begin
			res.kernel_value = kernel_of_sum(dist_acc, amp_reg)
				+ (it.on_diagonal ? {1'b0, noise_reg, 8'h00} : 25'd0);
			res.saturated = sat_seen;
			kernel_due.push_back(res);
			dist_acc = '0;
			coord_pos = '0;
			sat_seen = 1'b0;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dims_reg = 3'd4;
			for (int i = 0; i < MAX_DIM; i++)
				inv_reg[i] = 16'd256;
			amp_reg = 16'd256;
			noise_reg = 16'd0;
			dist_acc = '0;
			coord_pos = '0;
			sat_seen = 1'b0;
			kernel_due.delete();
			kernels_waiting <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_DIMS:    dims_reg = cfg_data[2:0];
					REG_INV_0:   inv_reg[0] = cfg_data;
					REG_INV_1:   inv_reg[1] = cfg_data;
					REG_INV_2:   inv_reg[2] = cfg_data;
					REG_INV_3:   inv_reg[3] = cfg_data;
					REG_SIG_VAR: amp_reg = cfg_data;
					REG_NOISE:   noise_reg = cfg_data;
					default: ; // index past the list: dropped
				endcase
			end
			// results first: the one leaving always belongs to an older item
			if (out_valid && out_ready) begin
				if (kernel_due.size() == 0) begin
					flag_mismatch($sformatf("result %0d/%0d with no kernel pending",
						out_data.kernel_value, out_data.saturated));
				end else begin
					due_head = kernel_due.pop_front();
					checked++;
					if (out_data.kernel_value !== due_head.kernel_value)
						flag_mismatch($sformatf("kernel_value %0d, expected %0d (result %0d)",
							out_data.kernel_value, due_head.kernel_value, checked));
					if (out_data.saturated !== due_head.saturated)
						flag_mismatch($sformatf("saturated %0b, expected %0b (result %0d)",
							out_data.saturated, due_head.saturated, checked));
				end
			end
			if (in_valid && in_ready)
				take_coord(in_data);
			kernels_waiting <= kernel_due.size();
		end
	end

endmodule

`default_nettype wire

@@ sim/ard_squared_exponential_kernel_unit_tb.sv @@
`default_nettype none

module ard_squared_exponential_kernel_unit_tb;
	import ardse_pkg::*;

	localparam int          SETTLE_CYCLES     = 40;
	localparam int          RUN_LIMIT         = 10_000_000;
	localparam int          SETTINGS          = 8;
	localparam int          ITEMS_PER_SETTING = 85;
	localparam logic [2:0]  REG_PAST_END      = 3'd7;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	ardse_in_t   in_data = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	ardse_out_t  out_data;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = '0;
	logic [15:0] cfg_data = '0;

	int          in_idle_pct = 31;
	int          out_idle_pct = 45;
	int          items_sent = 0;
	int          settings_run = 0;
	int          mismatch_count;
	int          kernels_waiting;
	int          kernels_checked;
	ardse_cfg_t  cur_cfg;

	ard_squared_exponential_kernel_unit DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	ard_squared_exponential_kernel_unit_checker u_kernel_check (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.in_data         (in_data),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.out_data        (out_data),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.mismatch_count  (mismatch_count),
		.kernels_waiting (kernels_waiting),
		.kernels_checked (kernels_checked)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= out_idle_pct);
	end

	task automatic put_coord(input logic [15:0] a, input logic [15:0] b, input logic diag);
		while ($urandom_range(99) < in_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= '{coord_first: a, coord_second: b, on_diagonal: diag};
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		items_sent++;
	endtask

	// wait out pending kernels, then any coordinate still in the datapath
	task automatic settle();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (kernels_waiting != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
	endtask

	task automatic apply_cfg(input ardse_cfg_t c);
		settle();
		write_reg(REG_DIMS, 16'(c.dims_in_use));
		write_reg(REG_INV_0, c.inv_len_sq[0]);
		write_reg(REG_INV_1, c.inv_len_sq[1]);
		write_reg(REG_INV_2, c.inv_len_sq[2]);
		write_reg(REG_INV_3, c.inv_len_sq[3]);
		write_reg(REG_SIG_VAR, c.signal_variance);
		write_reg(REG_NOISE, c.noise_variance);
		write_reg(REG_PAST_END, 16'($urandom));
		cfg_valid <= 1'b0;
		settings_run++;
	endtask

	function automatic logic [15:0] pick_coord();
		case ($urandom_range(9))
			0:       return 16'h0000;
			1:       return 16'hFFFF;
			2, 3:    return 16'($urandom_range(255));
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [15:0] pick_scale();
		case ($urandom_range(5))
			0:       return 16'h0000;
			1:       return 16'hFFFF;
			2, 3:    return 16'($urandom_range(1023));
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic put_random_coord();
		logic [15:0] a, b;
		a = pick_coord();
		case ($urandom_range(3))
			0:       b = a;
			1:       b = a + 16'($urandom_range(64)) - 16'd32;
			default: b = pick_coord();
		endcase
		put_coord(a, b, 1'($urandom));
	endtask

	initial begin
		#(RUN_LIMIT);
		$display("Timeout with %0d kernels still pending", kernels_waiting);
		$display("Test completed with failures");
		$finish;
	end

	initial begin
		ardse_cfg_t c;
		cur_cfg.dims_in_use = 3'd4;
		for (int i = 0; i < MAX_DIM; i++)
			cur_cfg.inv_len_sq[i] = 16'd256;
		cur_cfg.signal_variance = 16'd256;
		cur_cfg.noise_variance = 16'd0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// identical points: kernel equals the amplitude
		put_coord(16'h0000, 16'h0000, 1'b0);
		put_coord(16'hFFFF, 16'hFFFF, 1'b0);
		put_coord(16'h8000, 16'h8000, 1'b0);
		put_coord(16'h1234, 16'h1234, 1'b1);
		// widest spread on every axis
		put_coord(16'h0000, 16'hFFFF, 1'b0);
		put_coord(16'hFFFF, 16'h0000, 1'b0);
		put_coord(16'h0000, 16'hFFFF, 1'b0);
		put_coord(16'hFFFF, 16'h0000, 1'b1);
		// diagonal flag only counts on the last coordinate
		put_coord(16'h0001, 16'h0000, 1'b1);
		put_coord(16'h0000, 16'h0001, 1'b1);
		put_coord(16'hAAAA, 16'h5555, 1'b1);
		put_coord(16'h5555, 16'hAAAA, 1'b0);
		// count lowered mid-point: the next item closes the point
		put_coord(16'd100, 16'd200, 1'b1);
		put_coord(16'd300, 16'd0, 1'b0);
		cur_cfg.dims_in_use = 3'd2;
		cur_cfg.noise_variance = 16'h8000;
		apply_cfg(cur_cfg);
		put_coord(16'hFFFF, 16'h0000, 1'b1);
		// zero count acts as one
		cur_cfg.dims_in_use = 3'd0;
		cur_cfg.inv_len_sq[0] = 16'hFFFF;
		cur_cfg.signal_variance = 16'hFFFF;
		apply_cfg(cur_cfg);
		put_coord(16'h0000, 16'hFFFF, 1'b1);
		put_coord(16'h7FFF, 16'h8000, 1'b0);
		// count above the maximum acts as the maximum; everything at full scale saturates
		cur_cfg.dims_in_use = 3'd7;
		for (int i = 0; i < MAX_DIM; i++)
			cur_cfg.inv_len_sq[i] = 16'hFFFF;
		cur_cfg.noise_variance = 16'hFFFF;
		apply_cfg(cur_cfg);
		put_coord(16'h0000, 16'hFFFF, 1'b0);
		put_coord(16'h0000, 16'hFFFF, 1'b0);
		put_coord(16'h0000, 16'hFFFF, 1'b0);
		put_coord(16'hFFFF, 16'h0000, 1'b1);

		for (int s = 0; s < SETTINGS; s++) begin
			if (s == 0) begin
				c.dims_in_use = 3'd4;
				for (int i = 0; i < MAX_DIM; i++)
					c.inv_len_sq[i] = 16'hFFFF;
				c.signal_variance = 16'hFFFF;
				c.noise_variance = 16'hFFFF;
			end else if (s == 1) begin
				c.dims_in_use = 3'd1;
				for (int i = 0; i < MAX_DIM; i++)
					c.inv_len_sq[i] = 16'h0000;
				c.signal_variance = 16'h0000;
				c.noise_variance = 16'h0000;
			end else begin
				c.dims_in_use = 3'($urandom_range(7));
				for (int i = 0; i < MAX_DIM; i++)
					c.inv_len_sq[i] = pick_scale();
				c.signal_variance = 16'($urandom);
				c.noise_variance = 16'($urandom);
			end
			// idle pattern changes only between settings, while the block is quiet
			settle();
			if (s < 3) begin
				in_idle_pct = 31;
				out_idle_pct = 45;
			end else if (s < 6) begin
				in_idle_pct = 45;
				out_idle_pct = 31;
			end else begin
				in_idle_pct = 0;
				out_idle_pct = 0;
			end
			apply_cfg(c);
			for (int n = 0; n < ITEMS_PER_SETTING; n++)
				put_random_coord();
		end

		settle();
		$display("Drove %0d coordinate items through %0d register settings, %0d kernels checked.",
			items_sent, settings_run, kernels_checked);
		$display("Dimension counts 0..7, saturating sums, diagonal noise and stalls on both sides.");
		if (mismatch_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

`default_nettype wire
